// ===== hdl/mpp_pkg.sv =====
// types, constants and helper functions shared by the command parser
package mpp_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int OUT_WIDTH   = 64;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam value_t VAL_MASK = '1;

  localparam logic [2:0] ST_READ      = 3'd0;
  localparam logic [2:0] ST_WRITE     = 3'd1;
  localparam logic [2:0] ST_EXIT      = 3'd2;
  localparam logic [2:0] ST_BAD_PARAM = 3'd3;
  localparam logic [2:0] ST_ILLEGAL   = 3'd4;
  localparam logic [2:0] ST_TOK_COUNT = 3'd5;

  localparam logic [1:0] SZ_1 = 2'd0;
  localparam logic [1:0] SZ_2 = 2'd1;
  localparam logic [1:0] SZ_4 = 2'd2;
  localparam logic [1:0] SZ_8 = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [31:0] CMD_MM   = 32'h0000_6D6D;
  localparam logic [31:0] CMD_MM4  = 32'h006D_6D34;
  localparam logic [31:0] CMD_MM1  = 32'h006D_6D31;
  localparam logic [31:0] CMD_MM2  = 32'h006D_6D32;
  localparam logic [31:0] CMD_MM8  = 32'h006D_6D38;
  localparam logic [31:0] CMD_EXIT = 32'h6578_6974;

  localparam logic [2:0] TOK_MAX = 3'd4;
  localparam logic [1:0] LEN_MAX = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } mpp_byte_t;

  typedef struct packed {
    logic                 valid;
    logic [2:0]           status;
    logic [1:0]           size_code;
    logic [OUT_WIDTH-1:0] address;
    logic [OUT_WIDTH-1:0] write_data;
  } mpp_result_t;

  // {digit valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic value_t size_mask(input logic [1:0] sz);
    value_t m;
    case (sz)
      SZ_1:    m = value_t'(8'hFF);
      SZ_2:    m = value_t'(16'hFFFF);
      SZ_4:    m = value_t'(32'hFFFF_FFFF);
      default: m = VAL_MASK;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/mpp_char_if.sv =====
// input channel: one command byte per word
interface mpp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

// ===== hdl/mpp_result_if.sv =====
// result channel: one request or status word per line that holds a token
interface mpp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  size_code;
  logic [63:0] address;
  logic [63:0] write_data;

  modport source (output valid, output status, output size_code, output address,
                  output write_data, input ready);
  modport sink (input valid, input status, input size_code, input address,
                input write_data, output ready);
endinterface

// ===== hdl/memory_peek_poke_command_parser_top.sv =====
// top level of the memory peek/poke command parser
//
//   channel  | direction | word
//   in_if    | in        | char_in (one command byte)
//   out_if   | out       | status, size_code, address, write_data
//
// one byte per cycle unless a result stall holds it; a byte waits in the input
// register, and a newline's result is registered in the result register.
// rst_n is synchronous and clears all token and line state.
// a waiting result holds the byte stream only while out_if.ready is low;
// the input register keeps one byte during such a stall.
module memory_peek_poke_command_parser_top (
  input logic          clk,
  input logic          rst_n,
  mpp_char_if.sink     in_if,
  mpp_result_if.source out_if
);
  import mpp_pkg::*;

  mpp_byte_t   byte_q;
  mpp_result_t res;
  logic        advance;
  logic        take;

  assign take = byte_q.valid && advance;

  mpp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_char  (in_if.char_in),
    .in_ready (in_if.ready),
    .advance  (advance),
    .byte_q   (byte_q)
  );

  mpp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_q (byte_q),
    .take   (take),
    .res    (res)
  );

  mpp_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .take           (take),
    .advance        (advance),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_status     (out_if.status),
    .out_size_code  (out_if.size_code),
    .out_address    (out_if.address),
    .out_write_data (out_if.write_data)
  );
endmodule

// ===== hdl/mpp_in_stage.sv =====
// input register for received bytes
module mpp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_char,
  output logic              in_ready,
  input  logic              advance,
  output mpp_pkg::mpp_byte_t byte_q
);
  import mpp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] char_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r <= in_char;
    end
  end

  assign byte_q.valid = valid_r;
  assign byte_q.ch    = char_r;
endmodule

// ===== hdl/mpp_parser.sv =====
// token state and line decode for the command parser
module mpp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpp_pkg::mpp_byte_t   byte_q,
  input  logic                 take,
  output mpp_pkg::mpp_result_t res
);
  import mpp_pkg::*;

  logic        in_token_r, in_token_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [31:0] first_r, first_nxt;
  logic        too_long_r, too_long_nxt;
  logic        hexp_r, hexp_nxt;
  value_t      dec_r, dec_nxt;
  logic        stop_r, stop_nxt;
  value_t      hex_r, hex_nxt;
  logic        inv_r, inv_nxt;
  value_t      addr_r, addr_nxt;
  logic        addr_bad_r, addr_bad_nxt;
  value_t      data_r, data_nxt;
  logic        data_bad_r, data_bad_nxt;

  always_comb begin
    logic [7:0] c;
    logic [4:0] hn;
    logic       is_digit;
    value_t     fin_v;
    logic       fin_bad;
    value_t     addr_e;
    logic       addr_bad_e;
    value_t     data_e;
    logic       data_bad_e;
    logic       is_mm;
    logic [1:0] sz;
    logic [1:0] len_b;
    logic       hexp_b;
    value_t     dec_b;
    logic       stop_b;
    value_t     hex_b;
    logic       inv_b;

    c        = byte_q.ch;
    hn       = hex_nibble(c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    in_token_nxt = in_token_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    first_nxt    = first_r;
    too_long_nxt = too_long_r;
    hexp_nxt     = hexp_r;
    dec_nxt      = dec_r;
    stop_nxt     = stop_r;
    hex_nxt      = hex_r;
    inv_nxt      = inv_r;
    addr_nxt     = addr_r;
    addr_bad_nxt = addr_bad_r;
    data_nxt     = data_r;
    data_bad_nxt = data_bad_r;
    res          = '0;

    fin_v   = (hexp_r && len_r == LEN_MAX) ? hex_r : dec_r;
    fin_bad = inv_r || (&fin_v);

    addr_e     = (in_token_r && cnt_r == 3'd2) ? fin_v : addr_r;
    addr_bad_e = (in_token_r && cnt_r == 3'd2) ? fin_bad : addr_bad_r;
    data_e     = (in_token_r && cnt_r == 3'd3) ? fin_v : data_r;
    data_bad_e = (in_token_r && cnt_r == 3'd3) ? fin_bad : data_bad_r;

    is_mm = 1'b1;
    sz    = SZ_4;
    if (too_long_r) begin
      is_mm = 1'b0;
    end else if (first_r == CMD_MM || first_r == CMD_MM4) begin
      sz = SZ_4;
    end else if (first_r == CMD_MM1) begin
      sz = SZ_1;
    end else if (first_r == CMD_MM2) begin
      sz = SZ_2;
    end else if (first_r == CMD_MM8) begin
      sz = SZ_8;
    end else begin
      is_mm = 1'b0;
    end

    len_b  = in_token_r ? len_r : 2'd0;
    hexp_b = in_token_r ? hexp_r : 1'b0;
    dec_b  = in_token_r ? dec_r : '0;
    stop_b = in_token_r ? stop_r : 1'b0;
    hex_b  = in_token_r ? hex_r : '0;
    inv_b  = in_token_r ? inv_r : 1'b0;

    if (take) begin
      case (c)
        CH_NUL: begin
        end
        CH_SPACE: begin
          if (in_token_r) begin
            in_token_nxt = 1'b0;
            if (cnt_r == 3'd2) begin
              addr_nxt     = fin_v;
              addr_bad_nxt = fin_bad;
            end else if (cnt_r == 3'd3) begin
              data_nxt     = fin_v;
              data_bad_nxt = fin_bad;
            end
          end
        end
        CH_NL: begin
          if (cnt_r != 3'd0) begin
            res.valid = 1'b1;
            if (!is_mm) begin
              res.status = (!too_long_r && first_r == CMD_EXIT) ? ST_EXIT : ST_ILLEGAL;
            end else if (cnt_r == 3'd2) begin
              if (addr_bad_e) begin
                res.status = ST_BAD_PARAM;
              end else begin
                res.status    = ST_READ;
                res.size_code = sz;
                res.address   = OUT_WIDTH'(addr_e);
              end
            end else if (cnt_r == 3'd3) begin
              if (addr_bad_e || data_bad_e) begin
                res.status = ST_BAD_PARAM;
              end else begin
                res.status     = ST_WRITE;
                res.size_code  = sz;
                res.address    = OUT_WIDTH'(addr_e);
                res.write_data = OUT_WIDTH'(data_e & size_mask(sz));
              end
            end else begin
              res.status = ST_TOK_COUNT;
            end
          end
          in_token_nxt = 1'b0;
          cnt_nxt      = '0;
          len_nxt      = '0;
          first_nxt    = '0;
          too_long_nxt = 1'b0;
          hexp_nxt     = 1'b0;
          dec_nxt      = '0;
          stop_nxt     = 1'b0;
          hex_nxt      = '0;
          inv_nxt      = 1'b0;
          addr_nxt     = '0;
          addr_bad_nxt = 1'b0;
          data_nxt     = '0;
          data_bad_nxt = 1'b0;
        end
        default: begin
          in_token_nxt = 1'b1;
          if (!in_token_r && cnt_r < TOK_MAX) begin
            cnt_nxt = cnt_r + 3'd1;
          end
          if (cnt_nxt == 3'd1) begin
            if (first_r[31:24] != 8'd0) begin
              too_long_nxt = 1'b1;
            end
            first_nxt = {first_r[23:0], c};
          end
          inv_nxt = inv_b || (!hn[4] && c != CH_X);
          dec_nxt  = dec_b;
          stop_nxt = stop_b;
          if (!stop_b) begin
            if (is_digit) begin
              dec_nxt = (dec_b << 3) + (dec_b << 1) + value_t'(c[3:0]);
            end else begin
              stop_nxt = 1'b1;
            end
          end
          hexp_nxt = hexp_b;
          hex_nxt  = hex_b;
          if (len_b == 2'd0) begin
            hexp_nxt = (c == CH_ZERO);
          end else if (len_b == 2'd1) begin
            hexp_nxt = hexp_b && (c == CH_X);
          end else if (hn[4]) begin
            hex_nxt = {hex_b[VALUE_WIDTH-5:0], hn[3:0]};
          end
          len_nxt = (len_b < LEN_MAX) ? len_b + 2'd1 : len_b;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_token_r <= 1'b0;
      cnt_r      <= '0;
      len_r      <= '0;
      first_r    <= '0;
      too_long_r <= 1'b0;
      hexp_r     <= 1'b0;
      dec_r      <= '0;
      stop_r     <= 1'b0;
      hex_r      <= '0;
      inv_r      <= 1'b0;
      addr_r     <= '0;
      addr_bad_r <= 1'b0;
      data_r     <= '0;
      data_bad_r <= 1'b0;
    end else begin
      in_token_r <= in_token_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      first_r    <= first_nxt;
      too_long_r <= too_long_nxt;
      hexp_r     <= hexp_nxt;
      dec_r      <= dec_nxt;
      stop_r     <= stop_nxt;
      hex_r      <= hex_nxt;
      inv_r      <= inv_nxt;
      addr_r     <= addr_nxt;
      addr_bad_r <= addr_bad_nxt;
      data_r     <= data_nxt;
      data_bad_r <= data_bad_nxt;
    end
  end
endmodule

// ===== hdl/mpp_out_stage.sv =====
// result register holding one word until the sink takes it
module mpp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpp_pkg::mpp_result_t res,
  input  logic                 take,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [1:0]           out_size_code,
  output logic [63:0]          out_address,
  output logic [63:0]          out_write_data
);
  import mpp_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  mpp_result_t data_r;

  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = take && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take && res.valid) begin
      data_r <= res;
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = data_r.status;
  assign out_size_code  = data_r.size_code;
  assign out_address    = data_r.address;
  assign out_write_data = data_r.write_data;
endmodule

// ===== sim/testbench.sv =====
// testbench for the memory peek/poke command parser: directed and random command lines
`timescale 1ns / 100ps

module testbench;
  import mpp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_CHARS = 1540;
  localparam int PHASE_CHARS  = RANDOM_CHARS / 4;
  localparam int TAIL_CYCLES  = 8;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] size_code;
    value_t     address;
    value_t     write_data;
  } request_t;

  class request_tracker;
    request_t   awaited[$];
    int         mismatches;
    bit         in_tok;
    bit [2:0]   tok_cnt;
    bit [1:0]   tok_len;
    bit [31:0]  head;
    bit         head_long;
    bit         hex_pfx;
    value_t     dec_val;
    bit         dec_stop;
    value_t     hex_acc;
    bit         tok_bad;
    value_t     addr_val;
    bit         addr_bad;
    value_t     data_val;
    bit         data_bad;

    function void clear_line();
      in_tok = 0;
      tok_cnt = 0;
      tok_len = 0;
      head = 0;
      head_long = 0;
      hex_pfx = 0;
      dec_val = 0;
      dec_stop = 0;
      hex_acc = 0;
      tok_bad = 0;
      addr_val = 0;
      addr_bad = 0;
      data_val = 0;
      data_bad = 0;
    endfunction

    function int nibble(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void close_token();
      value_t v;
      bit     bad;
      if (!in_tok) return;
      in_tok = 0;
      v = (hex_pfx && tok_len == LEN_MAX) ? hex_acc : dec_val;
      bad = tok_bad || (v == VAL_MASK);
      if (tok_cnt == 2) begin
        addr_val = v;
        addr_bad = bad;
      end else if (tok_cnt == 3) begin
        data_val = v;
        data_bad = bad;
      end
    endfunction

    function void take_char(logic [7:0] c);
      int         h;
      bit         is_mm;
      logic [1:0] sz;
      request_t   r;
      if (c == CH_NUL) return;
      if (c == CH_SPACE) begin
        close_token();
        return;
      end
      if (c == CH_NL) begin
        close_token();
        if (tok_cnt != 0) begin
          r = '0;
          r.status = ST_ILLEGAL;
          is_mm = 0;
          sz = SZ_1;
          if (!head_long) begin
            case (head)
              CMD_MM, CMD_MM4: begin is_mm = 1; sz = SZ_4; end
              CMD_MM1:         begin is_mm = 1; sz = SZ_1; end
              CMD_MM2:         begin is_mm = 1; sz = SZ_2; end
              CMD_MM8:         begin is_mm = 1; sz = SZ_8; end
              CMD_EXIT:        r.status = ST_EXIT;
              default:         ;
            endcase
          end
          if (is_mm) begin
            if (tok_cnt == 2) begin
              if (addr_bad) begin
                r.status = ST_BAD_PARAM;
              end else begin
                r.status = ST_READ;
                r.size_code = sz;
                r.address = addr_val;
              end
            end else if (tok_cnt == 3) begin
              if (addr_bad || data_bad) begin
                r.status = ST_BAD_PARAM;
              end else begin
                r.status = ST_WRITE;
                r.size_code = sz;
                r.address = addr_val;
                r.write_data = data_val & value_t'((65'd1 << (8 << sz)) - 65'd1);
              end
            end else begin
              r.status = ST_TOK_COUNT;
            end
          end
          awaited.push_back(r);
        end
        clear_line();
        return;
      end
      h = nibble(c);
      if (!in_tok) begin
        in_tok = 1;
        if (tok_cnt < TOK_MAX) tok_cnt++;
        tok_len = 0;
        hex_pfx = 0;
        dec_val = 0;
        dec_stop = 0;
        hex_acc = 0;
        tok_bad = 0;
      end
      if (tok_cnt == 1) begin
        if (head[31:24] != 0) head_long = 1;
        head = {head[23:0], c};
      end
      if (h < 0 && c != CH_X) tok_bad = 1;
      if (!dec_stop) begin
        if (c >= CH_ZERO && c <= CH_NINE) dec_val = dec_val * 64'd10 + value_t'(c - CH_ZERO);
        else dec_stop = 1;
      end
      if (tok_len == 0) hex_pfx = (c == CH_ZERO);
      else if (tok_len == 1) hex_pfx = hex_pfx && (c == CH_X);
      else if (h >= 0) hex_acc = {hex_acc[VALUE_WIDTH-5:0], 4'(h)};
      if (tok_len < LEN_MAX) tok_len++;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task match_request(logic [2:0] st, logic [1:0] sz, value_t addr, value_t data);
      request_t e;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected word, status %0d", st));
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
      if (sz !== e.size_code)
        report_mismatch($sformatf("size_code %0d, expected %0d", sz, e.size_code));
      if (addr !== e.address)
        report_mismatch($sformatf("address %h, expected %h", addr, e.address));
      if (data !== e.write_data)
        report_mismatch($sformatf("write_data %h, expected %h", data, e.write_data));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mpp_char_if   in_if ();
  mpp_result_if out_if ();

  memory_peek_poke_command_parser_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  request_tracker tracker;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             hold_request = 0;
  int             hold_seen = 0;
  int             hold_left = 0;
  int             chars_sent = 0;
  int             cycles = 0;
  logic [7:0]     line_chars[$];
  string          mm_names[5] = '{"mm", "mm4", "mm1", "mm2", "mm8"};
  string          hex_set = "0123456789abcdefABCDEF";
  string          odd_set = "mmxeit41";

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end else if (rst_n) begin
      if (in_if.valid && in_if.ready) tracker.take_char(in_if.char_in);
      if (out_if.valid && out_if.ready)
        tracker.match_request(out_if.status, out_if.size_code, out_if.address,
                              out_if.write_data);
    end
  end

  task send_char(logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.char_in <= 8'($urandom);
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.char_in <= c;
    do @(posedge clk); while (!in_if.ready);
    if (c != CH_NUL) chars_sent++;
    @(negedge clk);
  endtask

  task send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task wait_drained();
    while (tracker.awaited.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function logic [7:0] token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_NL || b == CH_SPACE);
    return b;
  endfunction

  function void put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endfunction

  function void put_gap();
    int i;
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
    for (i = 0; i < n; i++) line_chars.push_back(CH_SPACE);
  endfunction

  function void put_command();
    int k;
    int i;
    int n;
    k = $urandom_range(0, 19);
    if (k < 15) begin
      put_text(mm_names[$urandom_range(0, 4)]);
    end else if (k < 17) begin
      put_text("exit");
    end else begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) line_chars.push_back(token_byte());
        else line_chars.push_back(odd_set[$urandom_range(0, 7)]);
      end
    end
  endfunction

  function void put_number();
    int i;
    int n;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        put_text("0x");
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 16);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 29) == 0) line_chars.push_back(CH_X);
          line_chars.push_back(hex_set[$urandom_range(0, 21)]);
        end
      end
      4, 5: begin
        n = $urandom_range(1, 21);
        for (i = 0; i < n; i++) line_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      6: begin
        put_text("0x");
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) line_chars.push_back(CH_ZERO);
        for (i = 0; i < 16; i++) line_chars.push_back($urandom_range(0, 1) ? "f" : "F");
      end
      7: put_text("18446744073709551615");
      8: begin
        case ($urandom_range(0, 2))
          0: put_text("0x");
          1: put_text("0");
          default: put_text("00x");
        endcase
      end
      9: begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) line_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0) line_chars.push_back(CH_X);
          else line_chars.push_back(hex_set[$urandom_range(0, 21)]);
        end
      end
      10: begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) line_chars.push_back(hex_set[$urandom_range(0, 21)]);
        line_chars.insert($urandom_range(0, line_chars.size()), token_byte());
      end
      default: begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) line_chars.push_back(token_byte());
      end
    endcase
  endfunction

  task send_random_line();
    int k;
    int i;
    int n;
    int ntok;
    line_chars.delete();
    k = $urandom_range(0, 99);
    if (k < 4) begin
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) line_chars.push_back(CH_SPACE);
    end else if (k < 9) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) begin
        line_chars.push_back(8'($urandom_range(0, 255)));
        if (line_chars[i] == CH_NL) line_chars[i] = CH_SPACE;
      end
    end else begin
      k = $urandom_range(0, 99);
      ntok = (k < 8) ? 1 : (k < 50) ? 2 : (k < 88) ? 3 : (k < 96) ? 4 : 5;
      if ($urandom_range(0, 9) == 0) put_gap();
      put_command();
      for (i = 2; i <= ntok; i++) begin
        put_gap();
        put_number();
      end
      if ($urandom_range(0, 9) == 0) put_gap();
      if ($urandom_range(0, 19) == 0)
        line_chars.insert($urandom_range(0, line_chars.size()), CH_NUL);
    end
    line_chars.push_back(CH_NL);
    foreach (line_chars[j]) send_char(line_chars[j]);
  endtask

  initial begin
    int base;
    int phase;
    int i;
    tracker = new;
    tracker.clear_line();
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.char_in = CH_NUL;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines
    send_text("\n");
    send_text("   \n");
    send_text("mm 0x0\n");
    send_text("mm4 0xffffffffffffffff\n");
    send_text("mm1 0x10 0x1ff\n");
    send_text("mm2 65536 0x12345\n");
    send_text("mm8 18446744073709551615\n");
    send_text("mm8 18446744073709551614 0xFEDCBA9876543210\n");
    send_text("mm 0x\n");
    send_text("mm 0x1x2 99999999999999999999\n");
    send_text("mm 12ab\n");
    send_text("mm 12g\n");
    send_text("mm\n");
    send_text("mm 1 2 3\n");
    send_text("exit\n");
    send_text("exit 1 2 3 4\n");
    send_text("mmm 1\n");
    send_text("axmm4 1\n");
    send_text("m");
    send_char(CH_NUL);
    send_text("m 5\n");
    send_text("  mm2   7   8  \n");
    send_text("mm ");
    send_char(8'hFF);
    send_text("\n");
    wait_drained();

    // random lines under four idling schemes
    base = chars_sent;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (phase == 0) begin
        hold_request++;
        for (i = 0; i < 12; i++) send_random_line();
      end
      if (phase == 3) wait_drained();
      while (chars_sent < base + (phase + 1) * PHASE_CHARS) send_random_line();
    end
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mpp_pkg.sv
hdl/mpp_char_if.sv
hdl/mpp_result_if.sv
hdl/mpp_in_stage.sv
hdl/mpp_parser.sv
hdl/mpp_out_stage.sv
hdl/memory_peek_poke_command_parser_top.sv
sim/testbench.sv
